@@ sv/vfcm_pkg.sv @@
// ----------------------------------------------------------------------------
// vfcm_pkg
// Shared types and constants of the voxel face-culling mesher.
// ----------------------------------------------------------------------------
package vfcm_pkg;

    // field widths fixed by the stream format
    localparam int COORD_W     = 4;
    localparam int SIZE_W      = 5;
    localparam int VERT_W      = 17;
    localparam int COLOR_DEPTH = 256;
    localparam int COLOR_AW    = 8;

    // empty-cell material id ('.')
    localparam logic [7:0] EMPTY_MARK = 8'd46;

    // vertices taken by one quad
    localparam logic [VERT_W-1:0] VERT_STEP = 17'd4;

    // command codes
    localparam logic [1:0] CMD_WRITE_VOXEL = 2'd0;
    localparam logic [1:0] CMD_WRITE_COLOR = 2'd1;
    localparam logic [1:0] CMD_MESH        = 2'd2;
    localparam logic [1:0] CMD_RESTART     = 2'd3;

    // face directions
    localparam logic [2:0] DIR_POS_X = 3'd0;
    localparam logic [2:0] DIR_NEG_X = 3'd1;
    localparam logic [2:0] DIR_POS_Y = 3'd2;
    localparam logic [2:0] DIR_NEG_Y = 3'd3;
    localparam logic [2:0] DIR_POS_Z = 3'd4;
    localparam logic [2:0] DIR_NEG_Z = 3'd5;

    // lookup steps of one mesh command: the cell itself, then the six neighbors
    localparam int         STEP_W      = 3;
    localparam logic [2:0] STEP_CENTER = 3'd0;
    localparam logic [2:0] STEP_LAST   = 3'd6;

    // configuration register indexes
    localparam logic CFG_EDGE_SIZE   = 1'b0;
    localparam logic CFG_LAYER_COUNT = 1'b1;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // input request as it sits on s_tdata
    typedef struct packed {
        logic [3:0]         pad;
        logic [7:0]         alpha;
        logic [7:0]         blue;
        logic [7:0]         green;
        logic [7:0]         red;
        logic [7:0]         material;
        logic [COORD_W-1:0] pos_z;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_x;
    } vfcm_in_t;

    // classified command held in the queue
    typedef struct packed {
        logic [1:0]         op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [7:0]         material;
        logic [31:0]        rgba;
    } vfcm_cmd_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic      valid;
        vfcm_cmd_t cmd;
    } vfcm_head_t;

    // face result as it sits on m_tdata
    typedef struct packed {
        logic [VERT_W-1:0]  first_vertex;
        logic [7:0]         alpha;
        logic [7:0]         blue;
        logic [7:0]         green;
        logic [7:0]         red;
        logic [COORD_W-1:0] cell_z;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] cell_x;
        logic [2:0]         face_dir;
    } vfcm_face_t;

endpackage

@@ sv/vfcm_ram.sv @@
// ----------------------------------------------------------------------------
// vfcm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vfcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, data held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/vfcm_front.sv @@
// ----------------------------------------------------------------------------
// vfcm_front
// Takes input requests, decodes the command and drops requests that have
// no effect (voxel writes beyond storage, meshes outside the active grid).
// ----------------------------------------------------------------------------
module vfcm_front
    import vfcm_pkg::*;
#(
    parameter int MAX_EDGE   = 16,
    parameter int MAX_LAYERS = 16
) (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [55:0]       s_tdata,
    input  logic [1:0]        s_tuser,
    input  logic [SIZE_W-1:0] act_edge,
    input  logic [SIZE_W-1:0] act_layers,
    input  logic              clear_busy,
    input  logic              q_full,
    output logic              push,
    output vfcm_cmd_t         push_cmd
);

    vfcm_in_t in_req;
    logic     in_storage;
    logic     in_active;
    logic     keep;

    assign in_req = vfcm_in_t'(s_tdata);

    // bounds of the stored grid and of the active grid
    assign in_storage = (int'(in_req.pos_x) < MAX_EDGE) && (int'(in_req.pos_z) < MAX_EDGE)
                     && (int'(in_req.pos_y) < MAX_LAYERS);
    assign in_active  = ({1'b0, in_req.pos_x} < act_edge) && ({1'b0, in_req.pos_z} < act_edge)
                     && ({1'b0, in_req.pos_y} < act_layers);

    // command classification
    always_comb
    begin
        unique case (s_tuser)
            CMD_WRITE_VOXEL: keep = in_storage;
            CMD_MESH:        keep = in_active;
            default:         keep = 1'b1;
        endcase
    end

    assign s_tready = !q_full && !clear_busy;
    assign push     = s_tvalid && s_tready && keep;

    assign push_cmd.op       = s_tuser;
    assign push_cmd.x        = in_req.pos_x;
    assign push_cmd.y        = in_req.pos_y;
    assign push_cmd.z        = in_req.pos_z;
    assign push_cmd.material = in_req.material;
    assign push_cmd.rgba     = {in_req.red, in_req.green, in_req.blue, in_req.alpha};

endmodule

@@ sv/vfcm_queue.sv @@
// ----------------------------------------------------------------------------
// vfcm_queue
// Small command FIFO between the front and the back end.
// ----------------------------------------------------------------------------
module vfcm_queue
    import vfcm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  vfcm_cmd_t  push_cmd,
    output logic       full,
    input  logic       pop,
    output vfcm_head_t head
);

    vfcm_cmd_t         q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = q_mem_reg[rd_ptr_reg];

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ sv/vfcm_back.sv @@
// ----------------------------------------------------------------------------
// vfcm_back
// Executes queued commands: owns the voxel grid and color table RAMs, runs
// the clearing pass after reset, gathers the seven lookups of a mesh command
// and, for an opaque cell, sends out one face per transparent neighbor.
// ----------------------------------------------------------------------------
module vfcm_back
    import vfcm_pkg::*;
#(
    parameter int MAX_EDGE   = 16,
    parameter int MAX_LAYERS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SIZE_W-1:0] act_edge,
    input  logic [SIZE_W-1:0] act_layers,
    input  vfcm_head_t        head,
    output logic              pop,
    output logic              clear_busy,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,
    output logic              m_tlast
);

    localparam int GRID_DEPTH = MAX_LAYERS * MAX_EDGE * MAX_EDGE;
    localparam int ADDR_W     = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
    localparam int CLEAR_LEN  = (GRID_DEPTH > COLOR_DEPTH) ? GRID_DEPTH : COLOR_DEPTH;
    localparam int CLR_W      = $clog2(CLEAR_LEN);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_GATHER = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    // linear grid address, x fastest, then z, then y
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [SIZE_W-1:0] x,
                                                     input logic [SIZE_W-1:0] y,
                                                     input logic [SIZE_W-1:0] z);
        int a;
        a = (int'(y) * MAX_EDGE + int'(z)) * MAX_EDGE + int'(x);
        return ADDR_W'(a);
    endfunction

    logic [1:0]         state_reg, state_next;
    logic [CLR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [VERT_W-1:0]  vcount_reg, vcount_next;
    logic [COORD_W-1:0] cx_reg, cx_next;
    logic [COORD_W-1:0] cy_reg, cy_next;
    logic [COORD_W-1:0] cz_reg, cz_next;
    logic [31:0]        col_reg, col_next;
    logic [5:0]         mask_reg, mask_next;
    logic [STEP_W-1:0]  issue_reg, issue_next;
    logic               p1_valid_reg, p1_valid_next;
    logic [STEP_W-1:0]  p1_step_reg, p1_step_next;
    logic               p1_out_reg, p1_out_next;
    logic               p2_valid_reg, p2_valid_next;
    logic [STEP_W-1:0]  p2_step_reg, p2_step_next;
    logic               out_valid_reg, out_valid_next;
    vfcm_face_t         out_face_reg, out_face_next;
    logic               out_last_reg, out_last_next;

    logic                grid_we;
    logic [ADDR_W-1:0]   grid_waddr;
    logic [7:0]          grid_wdata;
    logic                grid_re;
    logic [ADDR_W-1:0]   grid_raddr;
    logic [7:0]          grid_rdata;
    logic                color_we;
    logic [COLOR_AW-1:0] color_waddr;
    logic [31:0]         color_wdata;
    logic                color_re;
    logic [COLOR_AW-1:0] color_raddr;
    logic [31:0]         color_rdata;

    logic [STEP_W-1:0]   issue_dir;
    logic [SIZE_W-1:0]   nx, ny, nz;
    logic                n_under;
    logic                n_outside;
    logic                issuing;
    logic [2:0]          emit_dir;
    logic [5:0]          mask_rest;
    logic                out_free;
    logic [STEP_W-1:0]   p2_dir;

    // storage
    vfcm_ram #(
        .WIDTH (8),
        .DEPTH (GRID_DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_wdata),
        .re    (grid_re),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    vfcm_ram #(
        .WIDTH (32),
        .DEPTH (COLOR_DEPTH)
    ) u_color (
        .clk   (clk),
        .we    (color_we),
        .waddr (color_waddr),
        .wdata (color_wdata),
        .re    (color_re),
        .raddr (color_raddr),
        .rdata (color_rdata)
    );

    // neighbor coordinate of the lookup being issued
    assign issue_dir = issue_reg - 1'b1;

    always_comb
    begin
        nx      = {1'b0, cx_reg};
        ny      = {1'b0, cy_reg};
        nz      = {1'b0, cz_reg};
        n_under = 1'b0;
        unique case (issue_dir)
            DIR_POS_X: nx = nx + 1'b1;
            DIR_NEG_X:
            begin
                n_under = (cx_reg == '0);
                nx      = nx - 1'b1;
            end
            DIR_POS_Y: ny = ny + 1'b1;
            DIR_NEG_Y:
            begin
                n_under = (cy_reg == '0);
                ny      = ny - 1'b1;
            end
            DIR_POS_Z: nz = nz + 1'b1;
            DIR_NEG_Z:
            begin
                n_under = (cz_reg == '0);
                nz      = nz - 1'b1;
            end
            default: ;
        endcase
        n_outside = n_under || (nx >= act_edge) || (ny >= act_layers) || (nz >= act_edge);
    end

    // lowest pending face direction
    always_comb
    begin
        emit_dir = '0;
        for (int i = 5; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                emit_dir = 3'(i);
            end
        end
    end

    assign mask_rest = mask_reg & (mask_reg - 1'b1);
    assign out_free  = !out_valid_reg || m_tready;
    assign issuing   = (state_reg == ST_GATHER) && (issue_reg <= STEP_LAST);
    assign p2_dir    = p2_step_reg - 1'b1;

    // RAM read pipeline: grid lookup, then color lookup
    assign grid_re     = issuing;
    assign grid_raddr  = cell_addr(nx, ny, nz);
    assign color_re    = p1_valid_reg;
    assign color_raddr = p1_out_reg ? EMPTY_MARK : grid_rdata;

    // control and sequencing
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        vcount_next    = vcount_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        col_next       = col_reg;
        mask_next      = mask_reg;
        issue_next     = issue_reg;
        p1_valid_next  = issuing;
        p1_step_next   = issue_reg;
        p1_out_next    = n_outside;
        p2_valid_next  = p1_valid_reg;
        p2_step_next   = p1_step_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_face_next  = out_face_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        grid_we        = 1'b0;
        grid_waddr     = cell_addr({1'b0, head.cmd.x}, {1'b0, head.cmd.y}, {1'b0, head.cmd.z});
        grid_wdata     = head.cmd.material;
        color_we       = 1'b0;
        color_waddr    = head.cmd.material;
        color_wdata    = head.cmd.rgba;

        if (issuing)
        begin
            issue_next = issue_reg + 1'b1;
        end

        // color result of a lookup
        if (p2_valid_reg)
        begin
            if (p2_step_reg == STEP_CENTER)
            begin
                col_next = color_rdata;
            end
            else
            begin
                mask_next[p2_dir] = (color_rdata[7:0] == '0);
            end
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                grid_we     = (int'(clr_cnt_reg) < GRID_DEPTH);
                grid_waddr  = clr_cnt_reg[ADDR_W-1:0];
                grid_wdata  = EMPTY_MARK;
                color_we    = (int'(clr_cnt_reg) < COLOR_DEPTH);
                color_waddr = clr_cnt_reg[COLOR_AW-1:0];
                color_wdata = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_W'(CLEAR_LEN - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    unique case (head.cmd.op)
                        CMD_WRITE_VOXEL: grid_we = 1'b1;
                        CMD_WRITE_COLOR: color_we = 1'b1;
                        CMD_RESTART:     vcount_next = '0;
                        default:
                        begin
                            cx_next    = head.cmd.x;
                            cy_next    = head.cmd.y;
                            cz_next    = head.cmd.z;
                            issue_next = STEP_CENTER;
                            mask_next  = '0;
                            state_next = ST_GATHER;
                        end
                    endcase
                end
            end
            ST_GATHER:
            begin
                if (p2_valid_reg && (p2_step_reg == STEP_LAST))
                begin
                    state_next = (col_reg[7:0] != '0) ? ST_EMIT : ST_IDLE;
                end
            end
            default:
            begin
                if (mask_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_face_next.face_dir     = emit_dir;
                    out_face_next.cell_x       = cx_reg;
                    out_face_next.cell_y       = cy_reg;
                    out_face_next.cell_z       = cz_reg;
                    out_face_next.red          = col_reg[31:24];
                    out_face_next.green        = col_reg[23:16];
                    out_face_next.blue         = col_reg[15:8];
                    out_face_next.alpha        = col_reg[7:0];
                    out_face_next.first_vertex = vcount_reg;
                    out_last_next              = (mask_rest == '0);
                    vcount_next                = vcount_reg + VERT_STEP;
                    mask_next                  = mask_rest;
                    if (mask_rest == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            vcount_reg    <= '0;
            mask_reg      <= '0;
            issue_reg     <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            vcount_reg    <= vcount_next;
            mask_reg      <= mask_next;
            issue_reg     <= issue_next;
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cz_reg       <= cz_next;
        col_reg      <= col_next;
        p1_step_reg  <= p1_step_next;
        p1_out_reg   <= p1_out_next;
        p2_step_reg  <= p2_step_next;
        out_face_reg <= out_face_next;
        out_last_reg <= out_last_next;
    end

    assign clear_busy = (state_reg == ST_CLEAR);
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_face_reg;
    assign m_tlast    = out_last_reg;

endmodule

@@ sv/voxel_face_culling_mesher.sv @@
// ----------------------------------------------------------------------------
// voxel_face_culling_mesher
// Voxel grid mesher with face culling: a front end decodes commands into a
// short queue, a back end executes them against the grid and color RAMs.
//
//  channel | dir | signals                           | content
//  --------+-----+-----------------------------------+--------------------------
//  s_      | in  | s_tvalid s_tready s_tdata s_tuser | commands (tuser = opcode)
//  m_      | out | m_tvalid m_tready m_tdata m_tlast | faces (tlast = last face)
//  cfg_    | in  | cfg_we cfg_index cfg_data         | grid size registers
//
// In the back end a write or restart is done when it is popped; a mesh command
// first does its lookups (seven cells through the one read port of the grid RAM,
// then the color RAM) and then sends one face per cycle while m_ is not stalled.
// After reset a clearing pass over max(MAX_LAYERS*MAX_EDGE^2, 256) addresses fills
// the grid with the empty mark and zeroes the color table; s_tready stays low.
// A stalled m_ side holds the back end; the queue keeps the front taking
// commands until it fills.
// ----------------------------------------------------------------------------
module voxel_face_culling_mesher
    import vfcm_pkg::*;
#(
    parameter int MAX_EDGE   = 16,
    parameter int MAX_LAYERS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pos_x, pos_y, pos_z, material_id, in_red, in_green, in_blue, in_alpha, pad
    input  logic [55:0] s_tdata,
    // command
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // face_dir, cell_x, cell_y, cell_z, out_red, out_green, out_blue,
    // out_alpha, first_vertex
    output logic [63:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data
);

    logic [SIZE_W-1:0] edge_size_reg, edge_size_next;
    logic [SIZE_W-1:0] layer_count_reg, layer_count_next;
    logic [SIZE_W-1:0] act_edge;
    logic [SIZE_W-1:0] act_layers;
    logic              clear_busy;
    logic              q_full;
    logic              push;
    vfcm_cmd_t         push_cmd;
    logic              pop;
    vfcm_head_t        head;

    // configuration registers
    always_comb
    begin
        edge_size_next   = edge_size_reg;
        layer_count_next = layer_count_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EDGE_SIZE:   edge_size_next = cfg_data;
                default:         layer_count_next = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_size_reg   <= SIZE_W'(16);
            layer_count_reg <= SIZE_W'(16);
        end
        else
        begin
            edge_size_reg   <= edge_size_next;
            layer_count_reg <= layer_count_next;
        end
    end

    // active size, clamped to storage
    assign act_edge   = (int'(edge_size_reg) > MAX_EDGE) ? SIZE_W'(MAX_EDGE) : edge_size_reg;
    assign act_layers = (int'(layer_count_reg) > MAX_LAYERS) ? SIZE_W'(MAX_LAYERS)
                                                             : layer_count_reg;

    vfcm_front #(
        .MAX_EDGE   (MAX_EDGE),
        .MAX_LAYERS (MAX_LAYERS)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .act_edge   (act_edge),
        .act_layers (act_layers),
        .clear_busy (clear_busy),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    vfcm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .head     (head)
    );

    vfcm_back #(
        .MAX_EDGE   (MAX_EDGE),
        .MAX_LAYERS (MAX_LAYERS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .act_edge   (act_edge),
        .act_layers (act_layers),
        .head       (head),
        .pop        (pop),
        .clear_busy (clear_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

`ifndef SYNTHESIS
    // a face is only sent for an opaque cell
    a_face_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[46:39] != 8'd0))
        else $error("face sent with zero alpha");

    // direction code stays within the six faces
    a_face_dir: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] <= DIR_NEG_Z))
        else $error("face direction out of range");

    // quads start on a four-vertex boundary
    a_vertex_align: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[48:47] == 2'b00))
        else $error("first vertex not quad aligned");

    // no command taken while the clearing pass runs
    a_no_push_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !push && !pop)
        else $error("command moved during clearing pass");
`endif

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for voxel_face_culling_mesher. Requests are driven on the
// s_ stream with random gaps, faces are taken on the m_ stream with random
// stalls, and a scoreboard keeps its own grid, color table and vertex counter
// to predict every face. Directed corner cases come first, then random traffic
// over several grid sizes, then a short back-to-back mesh burst.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vfcm_pkg::*;

    localparam int LIMIT_CYCLES = 800000;
    localparam int SETTLE_CYCLES = 80;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS = 48;
    localparam int BURST_MESHES = 10;

    typedef struct {
        vfcm_face_t face;
        logic       last;
    } face_due_t;

    // ------------------------------------------------------------------------
    // scoreboard: shadow of the block state plus the queue of faces due
    // ------------------------------------------------------------------------
    class face_scoreboard;
        logic [7:0]        grid [4096];
        logic [31:0]       palette [256];
        logic [VERT_W-1:0] vcount;
        logic [SIZE_W-1:0] edge_len;
        logic [SIZE_W-1:0] layer_len;
        face_due_t         faces_due [$];
        int                fails;
        int                requests;
        int                meshes;
        int                faces_checked;

        function new();
            foreach (grid[i]) grid[i] = EMPTY_MARK;
            foreach (palette[i]) palette[i] = '0;
            vcount = '0;
            edge_len = 5'd16;
            layer_len = 5'd16;
            fails = 0;
            requests = 0;
            meshes = 0;
            faces_checked = 0;
        endfunction

        function void set_reg(logic idx, logic [SIZE_W-1:0] v);
            if (idx == CFG_EDGE_SIZE)
                edge_len = v;
            else
                layer_len = v;
        endfunction

        function int pending();
            return faces_due.size();
        endfunction

        function bit in_bounds(int x, int y, int z);
            int e;
            int l;
            e = (edge_len > 16) ? 16 : int'(edge_len);
            l = (layer_len > 16) ? 16 : int'(layer_len);
            return x >= 0 && y >= 0 && z >= 0 && x < e && z < e && y < l;
        endfunction

        // outside cells read as the empty mark
        function logic [31:0] color_of(int x, int y, int z);
            if (!in_bounds(x, y, z))
                return palette[EMPTY_MARK];
            return palette[grid[(y * 16 + z) * 16 + x]];
        endfunction

        function void note_request(logic [1:0] cmd, vfcm_in_t req);
            int x;
            int y;
            int z;
            int nx;
            int ny;
            int nz;
            logic [2:0] dir;
            logic [31:0] col;
            face_due_t due;
            int n;
            x = int'(req.pos_x);
            y = int'(req.pos_y);
            z = int'(req.pos_z);
            n = 0;
            requests++;
            case (cmd)
                CMD_WRITE_VOXEL: grid[(y * 16 + z) * 16 + x] = req.material;
                CMD_WRITE_COLOR:
                    palette[req.material] = {req.red, req.green, req.blue, req.alpha};
                CMD_RESTART: vcount = '0;
                default:
                begin
                    meshes++;
                    if (in_bounds(x, y, z))
                    begin
                        col = color_of(x, y, z);
                        if (col[7:0] != 8'd0)
                        begin
                            for (int d = 0; d < 6; d++)
                            begin
                                dir = d[2:0];
                                nx = x;
                                ny = y;
                                nz = z;
                                case (dir)
                                    DIR_POS_X: nx = x + 1;
                                    DIR_NEG_X: nx = x - 1;
                                    DIR_POS_Y: ny = y + 1;
                                    DIR_NEG_Y: ny = y - 1;
                                    DIR_POS_Z: nz = z + 1;
                                    default:   nz = z - 1;
                                endcase
                                if (color_of(nx, ny, nz) & 32'hFF)
                                    continue;
                                due.face.face_dir = dir;
                                due.face.cell_x = req.pos_x;
                                due.face.cell_y = req.pos_y;
                                due.face.cell_z = req.pos_z;
                                due.face.red = col[31:24];
                                due.face.green = col[23:16];
                                due.face.blue = col[15:8];
                                due.face.alpha = col[7:0];
                                due.face.first_vertex = vcount;
                                due.last = 1'b0;
                                vcount = vcount + VERT_STEP;
                                faces_due = {faces_due, due};
                                n++;
                            end
                            if (n > 0)
                                faces_due[faces_due.size() - 1].last = 1'b1;
                        end
                    end
                end
            endcase
        endfunction

        function void report_field(string fname, longint want, longint got);
            if (want != got)
            begin
                fails++;
                $display("%0t: face %0d field %s expected %0d actual %0d",
                         $time, faces_checked, fname, want, got);
            end
        endfunction

        function void check_face(vfcm_face_t got, logic got_last);
            face_due_t due;
            if (faces_due.size() == 0)
            begin
                fails++;
                $display("%0t: unexpected face expected none actual %h last %0d",
                         $time, got, got_last);
                return;
            end
            due = faces_due.pop_front();
            report_field("face_dir", due.face.face_dir, got.face_dir);
            report_field("cell_x", due.face.cell_x, got.cell_x);
            report_field("cell_y", due.face.cell_y, got.cell_y);
            report_field("cell_z", due.face.cell_z, got.cell_z);
            report_field("red", due.face.red, got.red);
            report_field("green", due.face.green, got.green);
            report_field("blue", due.face.blue, got.blue);
            report_field("alpha", due.face.alpha, got.alpha);
            report_field("first_vertex", due.face.first_vertex, got.first_vertex);
            report_field("last_face", due.last, got_last);
            faces_checked++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals and block instance
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = CMD_WRITE_VOXEL;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_EDGE_SIZE;
    logic [4:0]  cfg_data = '0;

    face_scoreboard sb = new();
    int  cycles = 0;
    int  rx_hold = 0;
    bit  burst = 1'b0;
    int  cur_edge = 16;
    int  cur_layers = 16;
    int  settings_used = 0;
    logic [7:0] pool [7] = '{8'd46, 8'd65, 8'd66, 8'd67, 8'd68, 8'd0, 8'd255};
    int  phase_edge [RANDOM_PHASES] = '{16, 1, 31, 3, 0, 8, 16, 5, 2};
    int  phase_layers [RANDOM_PHASES] = '{16, 1, 31, 7, 9, 16, 3, 2, 16};

    voxel_face_culling_mesher uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d faces outstanding", cycles,
                     sb.pending());
            $display("voxel_face_culling_mesher: mismatch");
            $finish;
        end
    end

    // face receiver: check at the edge, draw the next stall
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_face(vfcm_face_t'(m_tdata), m_tlast);
            rx_hold = burst ? 0 : int'($urandom_range(0, 10));
        end
    end

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold--;
        end
        else
            m_tready <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------
    task automatic send_request(logic [1:0] cmd, vfcm_in_t req);
        int gap;
        gap = burst ? 0 : int'($urandom_range(0, 10));
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= req;
        s_tuser <= cmd;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_request(cmd, req);
    endtask

    task automatic put_voxel(int x, int y, int z, logic [7:0] mat);
        vfcm_in_t req;
        req = '0;
        req.pos_x = 4'(x);
        req.pos_y = 4'(y);
        req.pos_z = 4'(z);
        req.material = mat;
        send_request(CMD_WRITE_VOXEL, req);
    endtask

    task automatic put_color(logic [7:0] mat, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b, logic [7:0] a);
        vfcm_in_t req;
        req = '0;
        req.pos_x = 4'($urandom_range(0, 15));
        req.pos_y = 4'($urandom_range(0, 15));
        req.pos_z = 4'($urandom_range(0, 15));
        req.material = mat;
        req.red = r;
        req.green = g;
        req.blue = b;
        req.alpha = a;
        send_request(CMD_WRITE_COLOR, req);
    endtask

    task automatic mesh_at(int x, int y, int z);
        vfcm_in_t req;
        req = '0;
        req.pos_x = 4'(x);
        req.pos_y = 4'(y);
        req.pos_z = 4'(z);
        req.material = 8'($urandom_range(0, 255));
        send_request(CMD_MESH, req);
    endtask

    task automatic restart_mesh();
        vfcm_in_t req;
        req = '0;
        req.material = 8'($urandom_range(0, 255));
        send_request(CMD_RESTART, req);
    endtask

    // drop valid, let all faces and the queued writes drain
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_size(int e, int l);
        wait_drained();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_EDGE_SIZE;
        cfg_data <= e[4:0];
        sb.set_reg(CFG_EDGE_SIZE, e[4:0]);
        @(negedge clk);
        cfg_index <= CFG_LAYER_COUNT;
        cfg_data <= l[4:0];
        sb.set_reg(CFG_LAYER_COUNT, l[4:0]);
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_edge = e;
        cur_layers = l;
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // random traffic helpers
    // ------------------------------------------------------------------------
    // mostly a small corner cluster so neighbors are populated
    function automatic int pick_coord(int span);
        int s;
        int cl;
        s = (span == 0 || span > 16) ? 16 : span;
        cl = (s < 6) ? s : 6;
        if ($urandom_range(0, 9) < 7)
            return int'($urandom_range(0, cl - 1));
        return int'($urandom_range(0, 15));
    endfunction

    function automatic logic [7:0] pick_material();
        if ($urandom_range(0, 99) < 85)
            return pool[$urandom_range(0, 6)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic run_random(int n);
        int roll;
        logic [7:0] mat;
        logic [7:0] a;
        for (int k = 0; k < n; k++)
        begin
            roll = int'($urandom_range(0, 99));
            if (roll < 35)
                put_voxel(pick_coord(cur_edge), pick_coord(cur_layers),
                          pick_coord(cur_edge), pick_material());
            else if (roll < 45)
            begin
                mat = pick_material();
                if (mat == EMPTY_MARK)
                    a = ($urandom_range(0, 99) < 85) ? 8'd0 : 8'($urandom_range(1, 255));
                else
                    a = ($urandom_range(0, 99) < 30) ? 8'd0 : 8'($urandom_range(1, 255));
                put_color(mat, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), a);
            end
            else if (roll < 95)
                mesh_at(pick_coord(cur_edge), pick_coord(cur_layers),
                        pick_coord(cur_edge));
            else
                restart_mesh();
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_size(16, 16);

        // empty grid: nothing opaque
        mesh_at(0, 0, 0);
        put_color(8'd65, 8'd255, 8'd0, 8'd128, 8'd255);
        put_color(8'd66, 8'd0, 8'd255, 8'd127, 8'd0);
        // lone corner voxel, all neighbors outside or empty
        put_voxel(0, 0, 0, 8'd65);
        mesh_at(0, 0, 0);
        put_voxel(1, 0, 0, 8'd65);
        mesh_at(0, 0, 0);
        // transparent material meshes to nothing
        put_voxel(0, 1, 0, 8'd66);
        mesh_at(0, 1, 0);
        put_voxel(15, 15, 15, 8'd65);
        mesh_at(15, 15, 15);
        // empty mark given a color: outside and empty turn opaque
        put_color(EMPTY_MARK, 8'd1, 8'd2, 8'd3, 8'd1);
        mesh_at(15, 15, 15);
        mesh_at(0, 2, 0);
        put_color(EMPTY_MARK, 8'd0, 8'd0, 8'd0, 8'd0);
        restart_mesh();
        put_color(8'd255, 8'd0, 8'd255, 8'd1, 8'd1);
        put_voxel(7, 8, 9, 8'd255);
        mesh_at(7, 8, 9);
        put_color(8'd0, 8'd128, 8'd64, 8'd32, 8'd16);
        put_voxel(15, 0, 15, 8'd0);
        mesh_at(15, 0, 15);

        // write beyond active size is kept for later
        set_size(4, 4);
        put_voxel(10, 10, 10, 8'd65);
        mesh_at(10, 10, 10);
        put_voxel(3, 3, 3, 8'd65);
        mesh_at(3, 3, 3);
        // zero sizes
        set_size(0, 16);
        mesh_at(0, 0, 0);
        set_size(16, 0);
        mesh_at(0, 0, 0);
        set_size(16, 16);
        mesh_at(10, 10, 10);

        // random traffic over several grid sizes
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_size(phase_edge[p], phase_layers[p]);
            burst = ($urandom_range(0, 3) == 0);
            run_random(PHASE_ITEMS);
            burst = 1'b0;
        end

        // isolated voxel meshed back to back, six faces each
        set_size(16, 16);
        put_color(EMPTY_MARK, 8'd0, 8'd0, 8'd0, 8'd0);
        put_color(8'd67, 8'd90, 8'd180, 8'd45, 8'd200);
        put_voxel(8, 8, 8, 8'd67);
        put_voxel(9, 8, 8, EMPTY_MARK);
        put_voxel(7, 8, 8, EMPTY_MARK);
        put_voxel(8, 9, 8, EMPTY_MARK);
        put_voxel(8, 7, 8, EMPTY_MARK);
        put_voxel(8, 8, 9, EMPTY_MARK);
        put_voxel(8, 8, 7, EMPTY_MARK);
        restart_mesh();
        burst = 1'b1;
        repeat (BURST_MESHES) mesh_at(8, 8, 8);
        burst = 1'b0;

        wait_drained();
        $display("ran %0d requests (%0d mesh) over %0d grid sizes", sb.requests,
                 sb.meshes, settings_used);
        $display("checked %0d faces, ending with a back-to-back mesh burst",
                 sb.faces_checked);
        if (sb.fails == 0 && sb.pending() == 0)
            $display("voxel_face_culling_mesher: match");
        else
            $display("voxel_face_culling_mesher: mismatch");
        $finish;
    end

endmodule

@@ voxel_face_culling_mesher.f @@
sv/vfcm_pkg.sv
sv/vfcm_ram.sv
sv/vfcm_front.sv
sv/vfcm_queue.sv
sv/vfcm_back.sv
sv/voxel_face_culling_mesher.sv
dv/tb.sv
